// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the positional list engine.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define PLE_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("assertion failed");

// Whenever the trigger holds, the outcome holds at the next clock edge.
`define PLE_ASSERT_NEXT(lbl, clk, rstn, trig, outcome) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |=> (outcome)) \
        else $error("assertion failed");

// Whenever the trigger holds, the outcome holds at the same clock edge.
`define PLE_ASSERT_SAME(lbl, clk, rstn, trig, outcome) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |-> (outcome)) \
        else $error("assertion failed");

`endif

// ===== design/ple_pkg.sv =====
// ---------------------------------------------------------------------------
// Positional list engine package
// Sizes, operation and status codes, and controller/datapath interfaces.
// ---------------------------------------------------------------------------
package ple_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam int AW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam int S_TDATA_W = ((VALUE_W + POS_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((STATUS_W + COUNT_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_POS   = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_BACK  = 3'd4,
        OP_DEL_POS   = 3'd5
    } op_e_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_e_t;

    typedef struct packed {
        logic      load;         // capture the accepted request
        logic      setup;        // set walk pointer and stop index
        logic      rd;           // read the neighbor of the walk pointer
        logic      wr_step;      // write it back one slot over and step
        logic      commit;       // place the value or drop the entry, update count
        logic      load_result;  // capture status and count into the output register
        status_e_t res_status;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            empty;
        logic            ins_pos_bad;
        logic            del_pos_bad;
        logic            walk_done;
    } stat_t;

    // Sign-extend the 32-bit input value, then keep its low DATA_WIDTH bits.
    function automatic logic [DATA_WIDTH-1:0] trim_value(input logic [VALUE_W-1:0] v);
        logic [63:0] ext;
        ext = {{(64 - VALUE_W){v[VALUE_W-1]}}, v};
        return ext[DATA_WIDTH-1:0];
    endfunction

endpackage

// ===== design/ple_ctrl.sv =====
// ---------------------------------------------------------------------------
// Positional list engine controller
// Sequences accept, decision, entry walk, commit and result hand-off.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ple_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  ple_pkg::stat_t stat,
    output ple_pkg::cmd_t  cmd
);
    import ple_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_WALK,
        S_WR,
        S_FINISH
    } state_t;

    state_t    state_reg, state_next;
    status_e_t st_reg, st_next;
    logic      commit_reg, commit_next;
    logic      m_tvalid_reg, m_tvalid_next;
    logic      out_free;
    logic      is_ins, is_del;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    assign is_ins = (stat.op == OP_INS_FRONT) || (stat.op == OP_INS_BACK) ||
                    (stat.op == OP_INS_POS);
    assign is_del = (stat.op == OP_DEL_FRONT) || (stat.op == OP_DEL_BACK) ||
                    (stat.op == OP_DEL_POS);

    always_comb begin
        state_next     = state_reg;
        st_next        = st_reg;
        commit_next    = commit_reg;
        m_tvalid_next  = m_tvalid_reg;
        cmd            = '0;
        cmd.res_status = st_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                // Full and empty are checked ahead of the position.
                commit_next = 1'b0;
                state_next  = S_FINISH;
                priority if (is_ins && stat.full) begin
                    st_next = ST_FULL;
                end else if (is_del && stat.empty) begin
                    st_next = ST_EMPTY;
                end else if (!is_ins && !is_del) begin
                    st_next = ST_RANGE;
                end else if ((stat.op == OP_INS_POS) && stat.ins_pos_bad) begin
                    st_next = ST_RANGE;
                end else if ((stat.op == OP_DEL_POS) && stat.del_pos_bad) begin
                    st_next = ST_RANGE;
                end else begin
                    st_next     = ST_DONE;
                    commit_next = 1'b1;
                    cmd.setup   = 1'b1;
                    state_next  = S_WALK;
                end
            end
            S_WALK: begin
                if (stat.walk_done) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.rd     = 1'b1;
                    state_next = S_WR;
                end
            end
            S_WR: begin
                cmd.wr_step = 1'b1;
                state_next  = S_WALK;
            end
            S_FINISH: begin
                if (out_free) begin
                    cmd.commit      = commit_reg;
                    cmd.load_result = 1'b1;
                    m_tvalid_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            st_reg       <= ST_DONE;
            commit_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            st_reg       <= st_next;
            commit_reg   <= commit_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    `PLE_ASSERT_SAME(a_result_slot_free, aclk, aresetn, cmd.load_result,
                     !m_tvalid_reg || m_tready)
    `PLE_ASSERT_NEXT(a_result_shown, aclk, aresetn, cmd.load_result, m_tvalid_reg)
    `PLE_ASSERT_SAME(a_commit_only_done, aclk, aresetn, cmd.commit, st_reg == ST_DONE)

endmodule

// ===== design/ple_dp.sv =====
// ---------------------------------------------------------------------------
// Positional list engine datapath
// Entry memory, entry count, walk pointer and result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ple_dp (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic [ple_pkg::S_TDATA_W-1:0]          s_tdata,
    input  logic [ple_pkg::OP_W-1:0]               s_tuser,
    input  ple_pkg::cmd_t                          cmd,
    output ple_pkg::stat_t                         stat,
    output logic [ple_pkg::STATUS_W-1:0]           res_status,
    output logic [ple_pkg::COUNT_W-1:0]            res_count
);
    import ple_pkg::*;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    logic [OP_W-1:0]       op_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [CNT_W-1:0]      occ_reg, occ_next;
    logic [AW-1:0]         ptr_reg, ptr_next;
    logic [AW-1:0]         stop_reg, stop_next;
    logic                  ins_dir_reg, ins_dir_next;
    logic [STATUS_W-1:0]   res_status_reg;
    logic [COUNT_W-1:0]    res_count_reg;

    logic [CMP_W-1:0]      pos_ext, occ_ext, occ_next_ext;
    logic [AW-1:0]         occ_idx, occ_last_idx, pos_idx, rd_addr;
    logic                  is_ins_op;

    assign pos_ext      = CMP_W'(pos_reg);
    assign occ_ext      = CMP_W'(occ_reg);
    assign occ_next_ext = CMP_W'(occ_next);
    assign occ_idx      = occ_ext[AW-1:0];
    assign occ_last_idx = occ_idx - AW'(1);
    assign pos_idx      = AW'(pos_ext - CMP_W'(1));
    assign is_ins_op    = (op_reg == OP_INS_FRONT) || (op_reg == OP_INS_BACK) ||
                          (op_reg == OP_INS_POS);

    assign stat.op          = op_reg;
    assign stat.full        = (occ_reg == CNT_W'(DEPTH));
    assign stat.empty       = (occ_reg == '0);
    assign stat.ins_pos_bad = (pos_reg == '0) || (pos_ext > occ_ext + CMP_W'(1));
    assign stat.del_pos_bad = (pos_reg == '0) || (pos_ext > occ_ext);
    assign stat.walk_done   = (ptr_reg == stop_reg);

    // An insert walks down from the tail, a delete walks up toward it.
    assign rd_addr = ins_dir_reg ? (ptr_reg - AW'(1)) : (ptr_reg + AW'(1));

    always_comb begin
        ptr_next     = ptr_reg;
        stop_next    = stop_reg;
        ins_dir_next = ins_dir_reg;
        occ_next     = occ_reg;

        if (cmd.setup) begin
            ins_dir_next = is_ins_op;
            if (is_ins_op) begin
                ptr_next = occ_idx;
                if (op_reg == OP_INS_FRONT) begin
                    stop_next = '0;
                end else if (op_reg == OP_INS_BACK) begin
                    stop_next = occ_idx;
                end else begin
                    stop_next = pos_idx;
                end
            end else begin
                stop_next = occ_last_idx;
                if (op_reg == OP_DEL_FRONT) begin
                    ptr_next = '0;
                end else if (op_reg == OP_DEL_BACK) begin
                    ptr_next = occ_last_idx;
                end else begin
                    ptr_next = pos_idx;
                end
            end
        end

        if (cmd.wr_step) begin
            ptr_next = rd_addr;
        end

        if (cmd.commit) begin
            occ_next = ins_dir_reg ? (occ_reg + CNT_W'(1)) : (occ_reg - CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            rdata_reg <= mem[rd_addr];
        end
        if (cmd.wr_step) begin
            mem[ptr_reg] <= rdata_reg;
        end else if (cmd.commit && ins_dir_reg) begin
            mem[stop_reg] <= val_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= s_tuser;
            val_reg <= trim_value(s_tdata[VALUE_W-1:0]);
            pos_reg <= s_tdata[VALUE_W +: POS_W];
        end
        ptr_reg     <= ptr_next;
        stop_reg    <= stop_next;
        ins_dir_reg <= ins_dir_next;
        if (cmd.load_result) begin
            res_status_reg <= cmd.res_status;
            res_count_reg  <= occ_next_ext[COUNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    assign res_status = res_status_reg;
    assign res_count  = res_count_reg;

    `PLE_ASSERT_ALWAYS(a_occ_bounded, aclk, aresetn, occ_reg <= CNT_W'(DEPTH))
    `PLE_ASSERT_NEXT(a_occ_held, aclk, aresetn, !cmd.commit, $stable(occ_reg))
    `PLE_ASSERT_SAME(a_insert_has_room, aclk, aresetn, cmd.commit && ins_dir_reg,
                     !stat.full)

endmodule

// ===== design/positional_list_engine.sv =====
// ---------------------------------------------------------------------------
// Positional list engine
// Bounded ordered list with front, back and positional insert and delete.
// ---------------------------------------------------------------------------
// One request is handled at a time. The list is held in order in a
// single-port entry memory. Each entry that has to move one slot is read and
// then written back one slot over.
// - Front inserts and deletes move every entry that stays in the list.
// - Back operations move no entry.
// - Rejected requests skip the walk.
// The next request is accepted once the result has been loaded, so a result
// can wait in the output register while that request is accepted.

module positional_list_engine (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [31:0] value, [38:32] position, upper bits zero
    input  logic [ple_pkg::S_TDATA_W-1:0]   s_tdata,
    // [2:0] opcode
    input  logic [ple_pkg::OP_W-1:0]        s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [1:0] status, [8:2] entry_count, upper bits zero
    output logic [ple_pkg::M_TDATA_W-1:0]   m_tdata
);
    import ple_pkg::*;

    cmd_t                cmd;
    stat_t               stat;
    logic [STATUS_W-1:0] res_status;
    logic [COUNT_W-1:0]  res_count;

    ple_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ple_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cmd        (cmd),
        .stat       (stat),
        .res_status (res_status),
        .res_count  (res_count)
    );

    assign m_tdata = {{(M_TDATA_W - STATUS_W - COUNT_W){1'b0}}, res_count, res_status};

endmodule
